// File: sv/sha1_hash_core_macros.svh
// ---------------------------------------------------------------------------
// sha1_hash_core_macros.svh
// Assertion helpers shared by the SHA-1 core modules.
// ---------------------------------------------------------------------------
`ifndef SHA1_HASH_CORE_MACROS_SVH
`define SHA1_HASH_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define SHA1HC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SHA1HC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/sha1hc_pkg.sv
// ---------------------------------------------------------------------------
// sha1hc_pkg
// Shared constants, codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package sha1hc_pkg;

  localparam int WordW    = 32;
  localparam int DigestW  = 160;
  localparam int BlkW     = 512;
  localparam int CntW     = 61;
  localparam int PosW     = 6;
  localparam int Rounds   = 80;
  localparam int RndW     = $clog2(Rounds);
  localparam int Phase1   = 20;
  localparam int Phase2   = 40;
  localparam int Phase3   = 60;

  localparam logic [PosW-1:0] PosBlkEnd = 6'd63;
  localparam logic [PosW-1:0] PosLenAt  = 6'd56;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  localparam logic [DigestW-1:0] HInit = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                          32'h10325476, 32'hC3D2E1F0};

  localparam logic [7:0] PadByte = 8'h80;

  // input action codes
  localparam logic [1:0] ACT_ADD     = 2'd0;
  localparam logic [1:0] ACT_ADD_FIN = 2'd1;
  localparam logic [1:0] ACT_FIN     = 2'd2;

  // byte shift operations into the block register
  localparam logic [2:0] BOP_NONE = 3'd0;
  localparam logic [2:0] BOP_DATA = 3'd1;
  localparam logic [2:0] BOP_PAD  = 3'd2;
  localparam logic [2:0] BOP_ZERO = 3'd3;
  localparam logic [2:0] BOP_LEN  = 3'd4;

  // round function groups
  localparam logic [1:0] PH_CH  = 2'd0;
  localparam logic [1:0] PH_PA1 = 2'd1;
  localparam logic [1:0] PH_MAJ = 2'd2;
  localparam logic [1:0] PH_PA2 = 2'd3;

  typedef struct packed {
    logic [2:0] byte_op;
    logic       load;     // working vars <= chain
    logic       round;    // one compression round
    logic [1:0] phase;
    logic       accum;    // chain += working vars
    logic       finish;   // digest out, chain back to init
  } sha1hc_cmd_t;

  typedef struct packed {
    logic pos_end;   // next byte fills the block
    logic pos_len;   // at the length field
    logic out_busy;  // digest still draining
  } sha1hc_sts_t;

endpackage

// File: sv/sha1hc_ctrl.sv
// ---------------------------------------------------------------------------
// sha1hc_ctrl
// Sequencer: byte intake, padding steps, round count, digest hand-off.
// ---------------------------------------------------------------------------
`include "sha1_hash_core_macros.svh"

module sha1hc_ctrl
  import sha1hc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_action,
  output logic        in_ready,
  input  sha1hc_sts_t sts,
  output sha1hc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD80 = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;

  logic [2:0]      state_r, state_nxt;
  logic [2:0]      ret_r, ret_nxt;     // where to go after this block
  logic            last_r, last_nxt;   // this block closes the message
  logic [RndW-1:0] rnd_r, rnd_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    ret_nxt   = ret_r;
    last_nxt  = last_r;
    rnd_nxt   = rnd_r;

    if (rnd_r < RndW'(Phase1)) begin
      cmd.phase = PH_CH;
    end else if (rnd_r < RndW'(Phase2)) begin
      cmd.phase = PH_PA1;
    end else if (rnd_r < RndW'(Phase3)) begin
      cmd.phase = PH_MAJ;
    end else begin
      cmd.phase = PH_PA2;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_ADD: begin
              cmd.byte_op = BOP_DATA;
              if (sts.pos_end) begin
                cmd.load  = 1'b1;
                state_nxt = S_ROUND;
                ret_nxt   = S_IDLE;
                last_nxt  = 1'b0;
                rnd_nxt   = '0;
              end
            end
            ACT_ADD_FIN: begin
              cmd.byte_op = BOP_DATA;
              if (sts.pos_end) begin
                cmd.load  = 1'b1;
                state_nxt = S_ROUND;
                ret_nxt   = S_PAD80;
                last_nxt  = 1'b0;
                rnd_nxt   = '0;
              end else begin
                state_nxt = S_PAD80;
              end
            end
            ACT_FIN: begin
              state_nxt = S_PAD80;
            end
            default: begin
              // unused code: taken and dropped
            end
          endcase
        end
      end
      S_PAD80: begin
        cmd.byte_op = BOP_PAD;
        if (sts.pos_end) begin
          cmd.load  = 1'b1;
          state_nxt = S_ROUND;
          ret_nxt   = S_PADZ;
          last_nxt  = 1'b0;
          rnd_nxt   = '0;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.pos_len) begin
          cmd.byte_op = BOP_LEN;
          cmd.load    = 1'b1;
          state_nxt   = S_ROUND;
          last_nxt    = 1'b1;
          rnd_nxt     = '0;
        end else begin
          cmd.byte_op = BOP_ZERO;
          if (sts.pos_end) begin
            cmd.load  = 1'b1;
            state_nxt = S_ROUND;
            ret_nxt   = S_PADZ;
            last_nxt  = 1'b0;
            rnd_nxt   = '0;
          end
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        rnd_nxt   = rnd_r + RndW'(1);
        if (rnd_r == RndW'(Rounds - 1)) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        if (last_r) begin
          if (!sts.out_busy) begin
            cmd.finish = 1'b1;
            state_nxt  = S_IDLE;
            last_nxt   = 1'b0;
          end
        end else begin
          cmd.accum = 1'b1;
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      last_r  <= 1'b0;
      rnd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      last_r  <= last_nxt;
      rnd_r   <= rnd_nxt;
    end
  end

  `SHA1HC_ASSERT_NOW(a_rnd_range, state_r == S_ROUND, rnd_r < RndW'(Rounds), "round count past 79")
  `SHA1HC_ASSERT_NOW(a_fin_free, cmd.finish, !sts.out_busy, "digest overwrites pending output")
  `SHA1HC_ASSERT_NEXT(a_load_round, cmd.load, state_r == S_ROUND && rnd_r == '0, "load without round start")

endmodule

// File: sv/sha1hc_dp.sv
// ---------------------------------------------------------------------------
// sha1hc_dp
// Block register / schedule, round unit, chaining words, digest output.
// ---------------------------------------------------------------------------
`include "sha1_hash_core_macros.svh"

module sha1hc_dp
  import sha1hc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sha1hc_cmd_t        cmd,
  input  logic [7:0]         in_data_byte,
  output sha1hc_sts_t        sts,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [WordW-1:0]   out_digest_word,
  output logic [2:0]         out_word_index,
  output logic               out_last_word
);

  // block bytes shift in at the low end; word i sits at bits 511-32i.
  // during rounds the same register is the 16-word schedule window.
  logic [BlkW-1:0]    blk_r;
  logic [DigestW-1:0] chain_r;
  logic [WordW-1:0]   a_r, b_r, c_r, d_r, e_r;
  logic [DigestW-1:0] dg_r;
  logic [2:0]         oidx_r;
  logic               ovalid_r;
  logic [CntW-1:0]    cnt_r;
  logic [PosW-1:0]    pos_r;

  logic [WordW-1:0]   w0, w2, w8, w13, w_new, f_val, k_val, t_val;
  logic [DigestW-1:0] sum;

  function automatic logic [WordW-1:0] blk_word(input logic [BlkW-1:0] b, input int i);
    blk_word = b[BlkW-1-WordW*i -: WordW];
  endfunction

  assign w0    = blk_word(blk_r, 0);
  assign w2    = blk_word(blk_r, 2);
  assign w8    = blk_word(blk_r, 8);
  assign w13   = blk_word(blk_r, 13);
  assign w_new = {w13[30:0] ^ w8[30:0] ^ w2[30:0] ^ w0[30:0],
                  w13[31] ^ w8[31] ^ w2[31] ^ w0[31]};

  always_comb begin
    case (cmd.phase)
      PH_CH: begin
        f_val = (b_r & c_r) | (~b_r & d_r);
        k_val = K0;
      end
      PH_PA1: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K1;
      end
      PH_MAJ: begin
        f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
        k_val = K2;
      end
      default: begin
        f_val = b_r ^ c_r ^ d_r;
        k_val = K3;
      end
    endcase
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w0;

  assign sum = {chain_r[159:128] + a_r, chain_r[127:96] + b_r, chain_r[95:64] + c_r,
                chain_r[63:32] + d_r, chain_r[31:0] + e_r};

  assign sts.pos_end  = (pos_r == PosBlkEnd);
  assign sts.pos_len  = (pos_r == PosLenAt);
  assign sts.out_busy = ovalid_r;

  // block register, working variables and digest register
  always_ff @(posedge clk) begin
    case (cmd.byte_op)
      BOP_DATA: blk_r <= {blk_r[BlkW-9:0], in_data_byte};
      BOP_PAD:  blk_r <= {blk_r[BlkW-9:0], PadByte};
      BOP_ZERO: blk_r <= {blk_r[BlkW-9:0], 8'h00};
      BOP_LEN:  blk_r <= {blk_r[BlkW-65:0], cnt_r, 3'b000};
      default: begin
        if (cmd.round) begin
          blk_r <= {blk_r[BlkW-WordW-1:0], w_new};
        end
      end
    endcase
    if (cmd.load) begin
      {a_r, b_r, c_r, d_r, e_r} <= chain_r;
    end else if (cmd.round) begin
      e_r <= d_r;
      d_r <= c_r;
      c_r <= {b_r[1:0], b_r[31:2]};
      b_r <= a_r;
      a_r <= t_val;
    end
    if (cmd.finish) begin
      dg_r <= sum;
    end else if (ovalid_r && out_ready) begin
      dg_r <= {dg_r[DigestW-WordW-1:0], {WordW{1'b0}}};
    end
  end

  // control state: counts, chaining words, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r  <= HInit;
      cnt_r    <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      case (cmd.byte_op)
        BOP_DATA: begin
          pos_r <= pos_r + PosW'(1);
          cnt_r <= cnt_r + CntW'(1);
        end
        BOP_PAD, BOP_ZERO: pos_r <= pos_r + PosW'(1);
        BOP_LEN:  pos_r <= '0;
        default: begin
        end
      endcase
      if (cmd.accum) begin
        chain_r <= sum;
      end
      if (cmd.finish) begin
        chain_r  <= HInit;
        cnt_r    <= '0;
        pos_r    <= '0;
        ovalid_r <= 1'b1;
        oidx_r   <= '0;
      end else if (ovalid_r && out_ready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd4) begin
          ovalid_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid       = ovalid_r;
  assign out_digest_word = dg_r[DigestW-1 -: WordW];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd4);

  `SHA1HC_ASSERT_NOW(a_oidx_range, ovalid_r, oidx_r <= 3'd4, "digest word index past 4")
  `SHA1HC_ASSERT_NEXT(a_fin_out, cmd.finish, ovalid_r && oidx_r == 3'd0, "finish did not start digest")
  `SHA1HC_ASSERT_NEXT(a_out_hold, ovalid_r && !out_ready, ovalid_r && $stable(dg_r) && $stable(oidx_r), "digest word changed while stalled")

endmodule

// File: sv/sha1_hash_core.sv
// ---------------------------------------------------------------------------
// sha1_hash_core
// SHA-1 over a byte stream: bytes in, five 32-bit digest words out.
// ---------------------------------------------------------------------------
//  channel | ports                                   | dir | word
//  --------+-----------------------------------------+-----+---------------------------
//  in      | in_valid/in_ready, in_action,in_data_byte| in  | one byte and/or finish
//  out     | out_valid/out_ready, out_digest_word,    | out | one digest word, MSW first
//          | out_word_index, out_last_word            |     |
//
// Bytes are taken while the core is idle; the 64th byte of a block starts 80
// rounds and then a fold step, and input stalls until the block is folded in.
// Finish walks the padding one byte per cycle, pausing for a compression when
// a block fills, then writes the length field and runs the last compression.
// The digest drains from its own register while the next message comes in; a
// second finish stalls input at the fold cycle until all five words are taken.
// rst_n is synchronous, active low, and restores the initial chaining words.
// ---------------------------------------------------------------------------
module sha1_hash_core
  import sha1hc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_action,
  input  logic [7:0]       in_data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WordW-1:0] out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  sha1hc_cmd_t cmd;   // sequencer -> datapath
  sha1hc_sts_t sts;   // datapath -> sequencer

  // sequencer: intake, padding order, round count
  sha1hc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: block/schedule shift register, round unit, digest register
  sha1hc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data_byte    (in_data_byte),
    .sts             (sts),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

endmodule

// File: verif/sha1_hash_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sha1_hash_core_tb
// Self-checking bench for the SHA-1 byte-stream core: a behavioral SHA-1
// predictor runs on every accepted byte word and queues the five digest
// words it expects; a checker pops them as the core hands them out.
// ---------------------------------------------------------------------------
module sha1_hash_core_tb;
  import sha1hc_pkg::*;

  localparam logic [1:0] ACT_NOP = 2'd3;  // unused code, core must drop it

  localparam logic [31:0] H0_INIT = 32'h67452301;
  localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
  localparam logic [31:0] H2_INIT = 32'h98BADCFE;
  localparam logic [31:0] H3_INIT = 32'h10325476;
  localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
  localparam logic [31:0] RC_CH   = 32'h5A827999;
  localparam logic [31:0] RC_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] RC_PAR2 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_MARK = 8'h80;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned RX_HOLD_CYCLES = 1500;
  localparam int unsigned DRAIN_CYCLES   = 400;   // > padding walk + two compressions
  localparam int unsigned IDLE_PCT       = 29;
  localparam int unsigned RANDOM_WORDS   = 260;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       in_action;
  logic [7:0]       in_data_byte;
  logic             out_valid;
  logic             out_ready;
  logic [WordW-1:0] out_digest_word;
  logic [2:0]       out_word_index;
  logic             out_last_word;

  // predictor state
  logic [31:0] chain_h [5];
  logic [7:0]  blk_buf [64];
  logic [60:0] msg_len;

  digest_word_t expected_digest_words [$];

  int unsigned n_errors;
  int unsigned cycle_cnt;
  int unsigned data_words_sent;  // byte/finish words, noise not counted
  bit          idle_on;
  bit          hold_request;

  sha1_hash_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // SHA-1 predictor
  // -------------------------------------------------------------------------
  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    chain_h[0] = H0_INIT;
    chain_h[1] = H1_INIT;
    chain_h[2] = H2_INIT;
    chain_h[3] = H3_INIT;
    chain_h[4] = H4_INIT;
    msg_len = '0;
  endfunction

  function automatic void sha1_compress_block();
    logic [31:0] sched [16];
    logic [31:0] a, b, c, d, e, f, k, wt, t;
    int r;
    for (r = 0; r < 16; r++)
      sched[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (r = 0; r < 80; r++) begin
      if (r < 16) begin
        wt = sched[r];
      end else begin
        // rolling 16-entry schedule window
        wt = rotl(sched[(r + 13) & 15] ^ sched[(r + 8) & 15] ^
                  sched[(r + 2) & 15] ^ sched[r & 15], 1);
        sched[r & 15] = wt;
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = RC_CH;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RC_PAR1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = RC_MAJ;
      end else begin
        f = b ^ c ^ d;
        k = RC_PAR2;
      end
      t = rotl(a, 5) + f + e + k + wt;
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  function automatic void sha1_take_byte(input logic [7:0] v);
    int pos;
    pos = int'(msg_len[5:0]);
    blk_buf[pos] = v;
    msg_len = msg_len + 61'd1;  // wraps mod 2^61
    if (pos == 63) sha1_compress_block();
  endfunction

  // pad, fold in the bit length, queue the five digest words
  function automatic void sha1_close_message();
    int pos;
    int i;
    logic [63:0] bit_len;
    digest_word_t dw;
    pos = int'(msg_len[5:0]);
    bit_len = {msg_len, 3'b000};
    blk_buf[pos] = PAD_MARK;
    pos++;
    if (pos > 56) begin
      // no room for the length: needs an extra block
      while (pos < 64) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      sha1_compress_block();
      pos = 0;
    end
    while (pos < 56) begin
      blk_buf[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) blk_buf[56 + i] = bit_len[63 - 8*i -: 8];
    sha1_compress_block();
    for (i = 0; i < 5; i++) begin
      dw.word = chain_h[i];
      dw.idx  = i[2:0];
      dw.last = (i == 4);
      expected_digest_words = {expected_digest_words, dw};
    end
    sha1_restart();
  endfunction

  function automatic void sha1_apply(input logic [1:0] act, input logic [7:0] v);
    case (act)
      ACT_ADD: begin
        sha1_take_byte(v);
      end
      ACT_ADD_FIN: begin
        sha1_take_byte(v);
        sha1_close_message();
      end
      ACT_FIN: begin
        sha1_close_message();
      end
      default: begin
        // unused code: no state change
      end
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // Called at a rising edge; returns at the edge that accepts the word.
  // Handshake is judged at the falling edge, where everything has settled.
  task automatic send_word(input logic [1:0] act, input logic [7:0] v);
    bit taken;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_action    <= act;
    in_data_byte <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_valid === 1'b1) && (in_ready === 1'b1);
      @(posedge clk);
    end
    sha1_apply(act, v);
  endtask

  // One message of len bytes; closes with a byte+finish word or a bare finish.
  // noisy sprinkles unused-code words in between.
  task automatic send_message(input int len, input bit noisy);
    bit fin_on_byte;
    int i;
    fin_on_byte = (len > 0) && $urandom_range(0, 1);
    for (i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 99) < 8) send_word(ACT_NOP, 8'($urandom));
      send_word((fin_on_byte && i == len - 1) ? ACT_ADD_FIN : ACT_ADD, 8'($urandom));
      data_words_sent++;
    end
    if (!fin_on_byte) begin
      send_word(ACT_FIN, 8'($urandom));
      data_words_sent++;
    end
  endtask

  // mostly short messages, a good share right at the padding boundaries
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 50) return $urandom_range(0, 12);
    if (sel < 75) begin
      case ($urandom_range(0, 7))
        0: return 55;   // last length with the bit count in the same block
        1: return 56;   // first length that spills into a second block
        2: return 57;
        3: return 63;
        4: return 64;   // full block, padding lands in a fresh one
        5: return 65;
        6: return 119;
        default: return 120;
      endcase
    end
    return $urandom_range(13, 130);
  endfunction

  // -------------------------------------------------------------------------
  // Output side
  // -------------------------------------------------------------------------
  task automatic note_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // ready pattern, plus a long counted hold when a test asks for one
  initial begin : digest_receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin : digest_checker
    digest_word_t exp_w;
    forever begin
      @(negedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_digest_words.size() == 0) begin
          note_error($sformatf("digest word %08h index %0d with nothing expected",
                               out_digest_word, out_word_index));
        end else begin
          exp_w = expected_digest_words.pop_front();
          if (out_digest_word !== exp_w.word || out_word_index !== exp_w.idx ||
              out_last_word !== exp_w.last) begin
            note_error($sformatf(
              "digest mismatch: exp word %08h idx %0d last %0b, got %08h idx %0d last %0b",
              exp_w.word, exp_w.idx, exp_w.last,
              out_digest_word, out_word_index, out_last_word));
          end
        end
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d digest words outstanding",
                 cycle_cnt, expected_digest_words.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // bare finish right after reset and again back to back; data byte ignored
  task automatic test_empty_message();
    send_word(ACT_FIN, 8'hA5);
    send_word(ACT_FIN, 8'h5A);
  endtask

  // one-byte messages at both byte extremes
  task automatic test_byte_extremes();
    send_word(ACT_ADD_FIN, 8'h00);
    send_word(ACT_ADD_FIN, 8'hFF);
  endtask

  // "abc" with unused-code words in between; they must not touch the hash
  task automatic test_ignored_action();
    send_word(ACT_NOP, 8'hFF);
    send_word(ACT_ADD, 8'h61);
    send_word(ACT_NOP, 8'h00);
    send_word(ACT_ADD, 8'h62);
    send_word(ACT_NOP, 8'h55);
    send_word(ACT_ADD_FIN, 8'h63);
  endtask

  // bytes then a separate finish word
  task automatic test_finish_after_bytes();
    send_word(ACT_ADD, 8'h80);
    send_word(ACT_ADD, 8'h7F);
    send_word(ACT_ADD, 8'hAA);
    send_word(ACT_FIN, 8'h00);
  endtask

  task automatic test_random_messages();
    idle_on = 1'b1;
    while (data_words_sent < RANDOM_WORDS) send_message(pick_length(), 1'b1);
  endtask

  // no idling on either side for a while
  task automatic test_full_rate();
    int i;
    idle_on = 1'b0;
    for (i = 0; i < 6; i++) send_message($urandom_range(0, 20), 1'b0);
    send_message(64, 1'b0);
    idle_on = 1'b1;
  endtask

  // receiver stops for a long stretch; one digest waits in the core and input stalls
  task automatic test_output_backpressure();
    int i;
    hold_request = 1'b1;
    for (i = 0; i < 5; i++) send_message($urandom_range(1, 6), 1'b0);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_action    = ACT_ADD;
    in_data_byte = 8'h00;
    out_ready    = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    n_errors     = 0;
    data_words_sent = 0;
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    sha1_restart();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_message();
    test_byte_extremes();
    test_ignored_action();
    test_finish_after_bytes();
    test_output_backpressure();
    test_full_rate();
    test_random_messages();

    in_valid <= 1'b0;
    while (expected_digest_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_digest_words.size() != 0)
      note_error($sformatf("%0d digest words never arrived", expected_digest_words.size()));
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
